// ----- rtl/qbve_pkg.sv -----
package qbve_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ColorW = 32;
  localparam int unsigned TexW   = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned CountW = 13;
  localparam int unsigned MqW    = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [MqW-1:0]    MqResetVal = 11'd1000;
  localparam logic [MqW-1:0]    MqMax      = 11'd1024;
  localparam logic [CountW-1:0] IdxPerQuad = 13'd6;
  localparam logic [ColorW-1:0] White      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_COLOR = 2'd0,
    MODE_TEX   = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_VERTEX = 2'd0,
    KIND_BIND   = 2'd1,
    KIND_DRAW   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_QUADS = 2'd0,
    CFG_EMPTY_TEX = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CLOSE_RD,
    ST_CLOSE_EMIT,
    ST_DRAW,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_ADD_X,
    ST_ADD_Y,
    ST_VERT
  } state_e;

  // signed add clamped to the 32-bit range
  function automatic logic signed [CoordW-1:0] sat_add(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    logic signed [CoordW:0] s;
    logic signed [CoordW-1:0] r;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      r = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      r = s[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/qbve_slot_ram.sv -----
module qbve_slot_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [qbve_pkg::TexW-1:0]    wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [qbve_pkg::TexW-1:0]    rdata_o
);

  logic [qbve_pkg::TexW-1:0] mem [DEPTH];
  logic [qbve_pkg::TexW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/quad_batch_vertex_expander_top.sv -----
// colored quad: dispatch, the x add and the y add, then one vertex per cycle while the
//   output is not stalled; the next item is taken once the last vertex is loaded
// a textured quad first reads and compares the bound slots one by one, with a slot write on a
//   miss; a batch close reads and emits one bind per used slot, then the draw result
// reset: batch empty, next free slot 1, max_quads 1000, empty texture id 0; the slot
//   table is not cleared, only entries below the next free slot are ever read
module quad_batch_vertex_expander_top #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [qbve_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [qbve_pkg::CoordW-1:0]  pos_y_i,
  input  logic signed [qbve_pkg::CoordW-1:0]  pos_z_i,
  input  logic signed [qbve_pkg::CoordW-1:0]  size_x_i,
  input  logic signed [qbve_pkg::CoordW-1:0]  size_y_i,
  input  logic [7:0]                          color_r_i,
  input  logic [7:0]                          color_g_i,
  input  logic [7:0]                          color_b_i,
  input  logic [7:0]                          color_a_i,
  input  logic [qbve_pkg::TexW-1:0]           texture_id_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [qbve_pkg::KindW-1:0]          kind_o,
  output logic signed [qbve_pkg::CoordW-1:0]  vert_x_o,
  output logic signed [qbve_pkg::CoordW-1:0]  vert_y_o,
  output logic signed [qbve_pkg::CoordW-1:0]  vert_z_o,
  output logic [qbve_pkg::ColorW-1:0]         color_rgba_o,
  output logic                                tex_u_o,
  output logic                                tex_v_o,
  output logic [qbve_pkg::SlotW-1:0]          slot_o,
  output logic [qbve_pkg::TexW-1:0]           bound_texture_o,
  output logic [qbve_pkg::CountW-1:0]         index_count_o,
  output logic                                last_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qbve_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  // slot address width and a count width that can hold SLOT_COUNT itself
  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned NW = $clog2(SLOT_COUNT + 1);
  localparam logic [NW-1:0] NfsFull = NW'(SLOT_COUNT - 1);

  qbve_pkg::state_e state_q, state_d;

  // configuration registers
  logic [qbve_pkg::MqW-1:0]    max_quads_q;
  logic [qbve_pkg::TexW-1:0]   empty_tex_q;

  // batch state
  logic [qbve_pkg::CountW-1:0] count_q;
  logic [NW-1:0]               nfs_q;

  // latched item
  qbve_pkg::mode_e             mode_q;
  logic signed [qbve_pkg::CoordW-1:0] px_q, py_q, pz_q, sx_q, sy_q;
  logic [qbve_pkg::ColorW-1:0] color_q;
  logic [qbve_pkg::TexW-1:0]   tex_q;

  // sequencer working registers
  logic [SW-1:0]               idx_q;
  logic [SW-1:0]               slot_q;
  logic [1:0]                  corner_q;
  logic signed [qbve_pkg::CoordW-1:0] sum_x_q, sum_y_q;

  // output register
  logic                        out_valid_q;
  logic [qbve_pkg::KindW-1:0]  kind_q;
  logic signed [qbve_pkg::CoordW-1:0] vx_q, vy_q, vz_q;
  logic [qbve_pkg::ColorW-1:0] col_q;
  logic                        u_q, v_q;
  logic [qbve_pkg::SlotW-1:0]  oslot_q;
  logic [qbve_pkg::TexW-1:0]   btex_q;
  logic [qbve_pkg::CountW-1:0] icnt_q;
  logic                        last_q;

  // slot ram
  logic                        ram_we;
  logic [qbve_pkg::TexW-1:0]   ram_rdata;

  // misc control
  logic                        in_accept;
  logic                        out_free;
  logic [qbve_pkg::MqW-1:0]    mq_eff;
  logic [qbve_pkg::CountW-1:0] thresh;
  logic                        close_needed;
  logic                        close_more;
  logic                        srch_miss;
  logic                        srch_hit;
  logic signed [qbve_pkg::CoordW-1:0] add_a, add_b, add_sum;

  // result being loaded this cycle
  logic                        out_load;
  logic [qbve_pkg::KindW-1:0]  r_kind;
  logic signed [qbve_pkg::CoordW-1:0] r_vx, r_vy, r_vz;
  logic [qbve_pkg::ColorW-1:0] r_col;
  logic                        r_u, r_v;
  logic [qbve_pkg::SlotW-1:0]  r_slot;
  logic [qbve_pkg::TexW-1:0]   r_btex;
  logic [qbve_pkg::CountW-1:0] r_icnt;
  logic                        r_last;

  assign in_stall_o  = (state_q != qbve_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // flush threshold is six indices per quad, max_quads clamped to 1..1024
  always_comb begin
    if (max_quads_q == '0) begin
      mq_eff = qbve_pkg::MqW'(1);
    end else if (max_quads_q > qbve_pkg::MqMax) begin
      mq_eff = qbve_pkg::MqMax;
    end else begin
      mq_eff = max_quads_q;
    end
    thresh = (qbve_pkg::CountW'(mq_eff) << 2) + (qbve_pkg::CountW'(mq_eff) << 1);
  end

  // close before a quad when the batch is full, or for a textured quad when no slot is left
  assign close_needed = (count_q >= thresh) ||
                        ((mode_q == qbve_pkg::MODE_TEX) && (nfs_q > NfsFull));
  assign close_more   = (NW'(idx_q) + NW'(1)) < nfs_q;
  assign srch_miss    = NW'(idx_q) >= nfs_q;
  assign srch_hit     = (ram_rdata == tex_q);

  // the one shared saturating adder: x in one cycle, y in the next
  assign add_a   = (state_q == qbve_pkg::ST_ADD_X) ? px_q : py_q;
  assign add_b   = (state_q == qbve_pkg::ST_ADD_X) ? sx_q : sy_q;
  assign add_sum = qbve_pkg::sat_add(add_a, add_b);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qbve_pkg::ST_IDLE: begin
        if (in_accept) state_d = qbve_pkg::ST_DISPATCH;
      end
      qbve_pkg::ST_DISPATCH: begin
        if (mode_q == qbve_pkg::MODE_NONE) begin
          state_d = qbve_pkg::ST_IDLE;
        end else if (mode_q == qbve_pkg::MODE_FLUSH || close_needed) begin
          state_d = qbve_pkg::ST_CLOSE_RD;
        end else if (mode_q == qbve_pkg::MODE_TEX) begin
          state_d = qbve_pkg::ST_SRCH_RD;
        end else begin
          state_d = qbve_pkg::ST_ADD_X;
        end
      end
      qbve_pkg::ST_CLOSE_RD: state_d = qbve_pkg::ST_CLOSE_EMIT;
      qbve_pkg::ST_CLOSE_EMIT: begin
        if (out_free) state_d = close_more ? qbve_pkg::ST_CLOSE_RD : qbve_pkg::ST_DRAW;
      end
      qbve_pkg::ST_DRAW: begin
        if (out_free) begin
          if (mode_q == qbve_pkg::MODE_FLUSH) begin
            state_d = qbve_pkg::ST_IDLE;
          end else if (mode_q == qbve_pkg::MODE_TEX) begin
            state_d = qbve_pkg::ST_SRCH_RD;
          end else begin
            state_d = qbve_pkg::ST_ADD_X;
          end
        end
      end
      qbve_pkg::ST_SRCH_RD: begin
        state_d = srch_miss ? qbve_pkg::ST_ADD_X : qbve_pkg::ST_SRCH_CMP;
      end
      qbve_pkg::ST_SRCH_CMP: begin
        state_d = srch_hit ? qbve_pkg::ST_ADD_X : qbve_pkg::ST_SRCH_RD;
      end
      qbve_pkg::ST_ADD_X: state_d = qbve_pkg::ST_ADD_Y;
      qbve_pkg::ST_ADD_Y: state_d = qbve_pkg::ST_VERT;
      qbve_pkg::ST_VERT: begin
        if (out_free && corner_q == 2'd3) state_d = qbve_pkg::ST_IDLE;
      end
      default: state_d = qbve_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: result to load and slot table write
  always_comb begin
    out_load = 1'b0;
    ram_we   = 1'b0;
    r_kind   = qbve_pkg::KIND_VERTEX;
    r_vx     = '0;
    r_vy     = '0;
    r_vz     = '0;
    r_col    = '0;
    r_u      = 1'b0;
    r_v      = 1'b0;
    r_slot   = '0;
    r_btex   = '0;
    r_icnt   = '0;
    r_last   = 1'b0;
    case (state_q)
      qbve_pkg::ST_CLOSE_EMIT: begin
        out_load = out_free;
        r_kind   = qbve_pkg::KIND_BIND;
        r_slot   = qbve_pkg::SlotW'(idx_q);
        // slot zero always binds the configured empty texture id
        r_btex   = (idx_q == '0) ? empty_tex_q : ram_rdata;
      end
      qbve_pkg::ST_DRAW: begin
        out_load = out_free;
        r_kind   = qbve_pkg::KIND_DRAW;
        r_icnt   = count_q;
        r_last   = (mode_q == qbve_pkg::MODE_FLUSH);
      end
      qbve_pkg::ST_SRCH_RD: begin
        ram_we = srch_miss;
      end
      qbve_pkg::ST_VERT: begin
        out_load = out_free;
        r_kind   = qbve_pkg::KIND_VERTEX;
        // corners walk (x,y) (x+w,y) (x+w,y+h) (x,y+h)
        r_u      = (corner_q == 2'd1) || (corner_q == 2'd2);
        r_v      = corner_q[1];
        r_vx     = r_u ? sum_x_q : px_q;
        r_vy     = r_v ? sum_y_q : py_q;
        r_vz     = pz_q;
        r_col    = (mode_q == qbve_pkg::MODE_TEX) ? qbve_pkg::White : color_q;
        r_slot   = qbve_pkg::SlotW'(slot_q);
        r_last   = (corner_q == 2'd3);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qbve_pkg::ST_IDLE;
      max_quads_q <= qbve_pkg::MqResetVal;
      empty_tex_q <= '0;
      count_q     <= '0;
      nfs_q       <= NW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          qbve_pkg::CFG_MAX_QUADS: max_quads_q <= cfg_data_i[qbve_pkg::MqW-1:0];
          qbve_pkg::CFG_EMPTY_TEX: empty_tex_q <= cfg_data_i;
          default: ;
        endcase
      end
      // draw result clears the batch
      if (state_q == qbve_pkg::ST_DRAW && out_free) begin
        count_q <= '0;
        nfs_q   <= NW'(1);
      end
      if (state_q == qbve_pkg::ST_SRCH_RD && srch_miss) begin
        nfs_q <= nfs_q + NW'(1);
      end
      if (state_q == qbve_pkg::ST_VERT && out_free && corner_q == 2'd3) begin
        count_q <= count_q + qbve_pkg::IdxPerQuad;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= qbve_pkg::mode_e'(mode_i);
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      sx_q     <= size_x_i;
      sy_q     <= size_y_i;
      color_q  <= {color_r_i, color_g_i, color_b_i, color_a_i};
      tex_q    <= texture_id_i;
    end
    case (state_q)
      qbve_pkg::ST_DISPATCH: begin
        slot_q   <= '0;
        corner_q <= '0;
        idx_q    <= (mode_q == qbve_pkg::MODE_TEX && !close_needed &&
                     mode_q != qbve_pkg::MODE_FLUSH) ? SW'(1) : '0;
      end
      qbve_pkg::ST_CLOSE_EMIT: begin
        if (out_free && close_more) idx_q <= idx_q + SW'(1);
      end
      qbve_pkg::ST_DRAW: begin
        if (out_free) idx_q <= SW'(1);
      end
      qbve_pkg::ST_SRCH_RD: begin
        if (srch_miss) slot_q <= nfs_q[SW-1:0];
      end
      qbve_pkg::ST_SRCH_CMP: begin
        if (srch_hit) begin
          slot_q <= idx_q;
        end else begin
          idx_q <= idx_q + SW'(1);
        end
      end
      qbve_pkg::ST_ADD_X: sum_x_q <= add_sum;
      qbve_pkg::ST_ADD_Y: sum_y_q <= add_sum;
      qbve_pkg::ST_VERT: begin
        if (out_free) corner_q <= corner_q + 2'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      kind_q  <= r_kind;
      vx_q    <= r_vx;
      vy_q    <= r_vy;
      vz_q    <= r_vz;
      col_q   <= r_col;
      u_q     <= r_u;
      v_q     <= r_v;
      oslot_q <= r_slot;
      btex_q  <= r_btex;
      icnt_q  <= r_icnt;
      last_q  <= r_last;
    end
  end

  // bound texture ids of slots one and up
  qbve_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nfs_q[SW-1:0]),
    .wdata_i (tex_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign vert_x_o        = vx_q;
  assign vert_y_o        = vy_q;
  assign vert_z_o        = vz_q;
  assign color_rgba_o    = col_q;
  assign tex_u_o         = u_q;
  assign tex_v_o         = v_q;
  assign slot_o          = oslot_q;
  assign bound_texture_o = btex_q;
  assign index_count_o   = icnt_q;
  assign last_o          = last_q;

endmodule

// ----- test/quad_expand_checker.sv -----
`timescale 1ns / 1ps

module quad_expand_checker #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [1:0]                       mode_i,
  input  logic [qbve_pkg::CoordW-1:0]      pos_x_i,
  input  logic [qbve_pkg::CoordW-1:0]      pos_y_i,
  input  logic [qbve_pkg::CoordW-1:0]      pos_z_i,
  input  logic [qbve_pkg::CoordW-1:0]      size_x_i,
  input  logic [qbve_pkg::CoordW-1:0]      size_y_i,
  input  logic [7:0]                       color_r_i,
  input  logic [7:0]                       color_g_i,
  input  logic [7:0]                       color_b_i,
  input  logic [7:0]                       color_a_i,
  input  logic [qbve_pkg::TexW-1:0]        texture_id_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [qbve_pkg::KindW-1:0]       kind_i,
  input  logic [qbve_pkg::CoordW-1:0]      vert_x_i,
  input  logic [qbve_pkg::CoordW-1:0]      vert_y_i,
  input  logic [qbve_pkg::CoordW-1:0]      vert_z_i,
  input  logic [qbve_pkg::ColorW-1:0]      color_rgba_i,
  input  logic                             tex_u_i,
  input  logic                             tex_v_i,
  input  logic [qbve_pkg::SlotW-1:0]       slot_i,
  input  logic [qbve_pkg::TexW-1:0]        bound_texture_i,
  input  logic [qbve_pkg::CountW-1:0]      index_count_i,
  input  logic                             last_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [qbve_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               checked_o
);

  import qbve_pkg::*;

  typedef struct packed {
    kind_e               kind;
    logic [CoordW-1:0]   vx;
    logic [CoordW-1:0]   vy;
    logic [CoordW-1:0]   vz;
    logic [ColorW-1:0]   rgba;
    logic                u;
    logic                v;
    logic [SlotW-1:0]    slot;
    logic [TexW-1:0]     bound;
    logic [CountW-1:0]   count;
    logic                last;
  } emit_t;

  emit_t             emit_q[$];
  logic [CountW-1:0] batch_idx;
  logic [TexW-1:0]   slot_tab [SLOT_COUNT];
  int                next_slot;
  logic [MqW-1:0]    cfg_mq;
  logic [TexW-1:0]   empty_tex;
  int                n_fail = 0;
  int                n_checked = 0;

  function automatic logic [CoordW-1:0] clamp_sum(input logic signed [CoordW-1:0] a,
                                                  input logic signed [CoordW-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[CoordW-1:0];
  endfunction

  // one bind per used slot, then the draw; the batch starts over
  function automatic void close_batch_pred(input bit mark_last);
    int    n;
    emit_t e;
    n = (next_slot > SLOT_COUNT) ? SLOT_COUNT : next_slot;
    for (int i = 0; i < n; i++) begin
      e = '0;
      e.kind  = KIND_BIND;
      e.slot  = SlotW'(i);
      e.bound = (i == 0) ? empty_tex : slot_tab[i];
      emit_q.push_back(e);
    end
    e = '0;
    e.kind  = KIND_DRAW;
    e.count = batch_idx;
    e.last  = mark_last;
    emit_q.push_back(e);
    batch_idx = '0;
    next_slot = 1;
  endfunction

  function automatic void expand_cmd(input mode_e m,
                                     input logic [CoordW-1:0] px, py, pz, sx, sy,
                                     input logic [ColorW-1:0] rgba_in,
                                     input logic [TexW-1:0] tex);
    int                mq;
    int                slot;
    bit                hit;
    logic [ColorW-1:0] rgba;
    logic [CoordW-1:0] xs [4];
    logic [CoordW-1:0] ys [4];
    emit_t             e;
    if (m == MODE_NONE) return;
    if (m == MODE_FLUSH) begin
      close_batch_pred(1'b1);
      return;
    end
    mq = int'(cfg_mq);
    if (mq < 1) mq = 1;
    if (mq > int'(MqMax)) mq = int'(MqMax);
    if (int'(batch_idx) >= 6 * mq || (m == MODE_TEX && next_slot > SLOT_COUNT - 1)) begin
      close_batch_pred(1'b0);
    end
    slot = 0;
    rgba = rgba_in;
    if (m == MODE_TEX) begin
      hit = 1'b0;
      for (int i = 1; i < next_slot && i < SLOT_COUNT; i++) begin
        if (!hit && slot_tab[i] == tex) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        slot = next_slot;
        if (slot < SLOT_COUNT) slot_tab[slot] = tex;
        next_slot++;
      end
      rgba = White;
    end
    xs[0] = px;
    ys[0] = py;
    xs[1] = clamp_sum(px, sx);
    ys[1] = py;
    xs[2] = xs[1];
    ys[2] = clamp_sum(py, sy);
    xs[3] = px;
    ys[3] = ys[2];
    for (int c = 0; c < 4; c++) begin
      e = '0;
      e.kind = KIND_VERTEX;
      e.vx   = xs[c];
      e.vy   = ys[c];
      e.vz   = pz;
      e.rgba = rgba;
      e.u    = (c == 1 || c == 2);
      e.v    = (c >= 2);
      e.slot = SlotW'(slot);
      e.last = (c == 3);
      emit_q.push_back(e);
    end
    batch_idx = batch_idx + IdxPerQuad;
  endfunction

  function automatic void show_result(input string tag, input emit_t e);
    $display("  %s kind %0d x %h y %h z %h rgba %h u %0d v %0d", tag, e.kind, e.vx, e.vy,
             e.vz, e.rgba, e.u, e.v);
    $display("  %s slot %0d tex %h count %0d last %0d", tag, e.slot, e.bound, e.count,
             e.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    emit_t got;
    emit_t want;
    if (!rst_ni) begin
      emit_q.delete();
      batch_idx = '0;
      next_slot = 1;
      cfg_mq    = MqResetVal;
      empty_tex = '0;
      pending_o    <= 0;
      fail_count_o <= n_fail;
      checked_o    <= n_checked;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_QUADS: cfg_mq = cfg_data_i[MqW-1:0];
          CFG_EMPTY_TEX: empty_tex = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.kind  = kind_e'(kind_i);
        got.vx    = vert_x_i;
        got.vy    = vert_y_i;
        got.vz    = vert_z_i;
        got.rgba  = color_rgba_i;
        got.u     = tex_u_i;
        got.v     = tex_v_i;
        got.slot  = slot_i;
        got.bound = bound_texture_i;
        got.count = index_count_i;
        got.last  = last_i;
        if (emit_q.size() == 0) begin
          if (n_fail < 10) begin
            $display("[%0t] result with nothing pending", $realtime);
            show_result("actual  ", got);
          end
          n_fail++;
        end else begin
          want = emit_q.pop_front();
          n_checked++;
          if (got !== want) begin
            if (n_fail < 10) begin
              $display("[%0t] mismatch on result %0d", $realtime, n_checked);
              show_result("expected", want);
              show_result("actual  ", got);
            end
            n_fail++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expand_cmd(mode_e'(mode_i), pos_x_i, pos_y_i, pos_z_i, size_x_i, size_y_i,
                   {color_r_i, color_g_i, color_b_i, color_a_i}, texture_id_i);
      end
      pending_o    <= emit_q.size();
      fail_count_o <= n_fail;
      checked_o    <= n_checked;
    end
  end

endmodule

// ----- test/quad_batch_vertex_expander_top_tb.sv -----
`timescale 1ns / 1ps

module quad_batch_vertex_expander_top_tb;

  import qbve_pkg::*;

  localparam int unsigned SlotCount = 32;
  localparam int HoldCycles   = 400;   // long output hold, block must back up
  localparam int SettleCycles = 80;    // covers an ignored item still in flight
  localparam int TailCycles   = 100;
  localparam int IdleLimit    = 3000;  // several times the longest quiet stretch

  typedef struct {
    mode_e       mode;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] rgba;
    logic [31:0] tex;
  } quad_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  // input item channel, all known from time zero
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        mode     = '0;
  logic [31:0]       pos_x    = '0;
  logic [31:0]       pos_y    = '0;
  logic [31:0]       pos_z    = '0;
  logic [31:0]       size_x   = '0;
  logic [31:0]       size_y   = '0;
  logic [7:0]        color_r  = '0;
  logic [7:0]        color_g  = '0;
  logic [7:0]        color_b  = '0;
  logic [7:0]        color_a  = '0;
  logic [31:0]       tex_id   = '0;

  // result item channel
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KindW-1:0]  out_kind;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;
  logic [CoordW-1:0] out_z;
  logic [ColorW-1:0] out_rgba;
  logic              out_u;
  logic              out_v;
  logic [SlotW-1:0]  out_slot;
  logic [TexW-1:0]   out_bound;
  logic [CountW-1:0] out_count;
  logic              out_last;

  // register write channel
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data  = '0;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  logic [31:0] recent_tex [8];
  bit          hold_req  = 1'b0;
  int          n_color   = 0;
  int          n_tex     = 0;
  int          n_flush   = 0;
  int          n_ignored = 0;
  int          n_cfg     = 0;
  int          n_holds   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  quad_batch_vertex_expander_top #(
    .SLOT_COUNT(SlotCount)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .size_x_i       (size_x),
    .size_y_i       (size_y),
    .color_r_i      (color_r),
    .color_g_i      (color_g),
    .color_b_i      (color_b),
    .color_a_i      (color_a),
    .texture_id_i   (tex_id),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (out_kind),
    .vert_x_o       (out_x),
    .vert_y_o       (out_y),
    .vert_z_o       (out_z),
    .color_rgba_o   (out_rgba),
    .tex_u_o        (out_u),
    .tex_v_o        (out_v),
    .slot_o         (out_slot),
    .bound_texture_o(out_bound),
    .index_count_o  (out_count),
    .last_o         (out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // checker sits beside the block and only watches the channels
  quad_expand_checker #(
    .SLOT_COUNT(SlotCount)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .size_x_i       (size_x),
    .size_y_i       (size_y),
    .color_r_i      (color_r),
    .color_g_i      (color_g),
    .color_b_i      (color_b),
    .color_a_i      (color_a),
    .texture_id_i   (tex_id),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kind_i         (out_kind),
    .vert_x_i       (out_x),
    .vert_y_i       (out_y),
    .vert_z_i       (out_z),
    .color_rgba_i   (out_rgba),
    .tex_u_i        (out_u),
    .tex_v_i        (out_v),
    .slot_i         (out_slot),
    .bound_texture_i(out_bound),
    .index_count_i  (out_count),
    .last_i         (out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  function automatic quad_cmd_t mk(input mode_e m,
                                   input logic [31:0] px, py, pz, sx, sy, rgba, tex);
    quad_cmd_t c;
    c.mode   = m;
    c.pos_x  = px;
    c.pos_y  = py;
    c.pos_z  = pz;
    c.size_x = sx;
    c.size_y = sy;
    c.rgba   = rgba;
    c.tex    = tex;
    return c;
  endfunction

  // coordinates lean on the saturation corners now and then
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h00FF_FFFF);
      3: return 32'h0 - $urandom_range(1, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // fresh_pct steers texture ids between new ones and ones seen lately
  function automatic quad_cmd_t make_cmd(input int tex_pct, input int fresh_pct,
                                         input int flush_pct);
    quad_cmd_t c;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < flush_pct) c.mode = MODE_FLUSH;
    else if (pick < flush_pct + 3) c.mode = MODE_NONE;
    else if ($urandom_range(0, 99) < tex_pct) c.mode = MODE_TEX;
    else c.mode = MODE_COLOR;
    c.pos_x  = pick_coord();
    c.pos_y  = pick_coord();
    c.pos_z  = ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom;
    c.size_x = pick_coord();
    c.size_y = pick_coord();
    c.rgba   = $urandom;
    if ($urandom_range(0, 99) < fresh_pct) c.tex = $urandom;
    else c.tex = recent_tex[$urandom_range(0, 7)];
    return c;
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_cmd(input quad_cmd_t c);
    in_valid <= 1'b1;
    mode     <= c.mode;
    pos_x    <= c.pos_x;
    pos_y    <= c.pos_y;
    pos_z    <= c.pos_z;
    size_x   <= c.size_x;
    size_y   <= c.size_y;
    color_r  <= c.rgba[31:24];
    color_g  <= c.rgba[23:16];
    color_b  <= c.rgba[15:8];
    color_a  <= c.rgba[7:0];
    tex_id   <= c.tex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (c.mode)
      MODE_COLOR: n_color++;
      MODE_TEX: begin
        n_tex++;
        recent_tex[$urandom_range(0, 7)] = c.tex;
      end
      MODE_FLUSH: n_flush++;
      default: n_ignored++;
    endcase
  endtask

  // first waits for a clock edge so the count already holds the last accepted item
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // both registers in one transfer train, valid stays up in between
  task automatic set_config(input logic [31:0] mq_word, input logic [31:0] empty_word);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_QUADS;
    cfg_data  <= mq_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_EMPTY_TEX;
    cfg_data  <= empty_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // random items in bursts; optional long output hold and a full drain midway
  task automatic run_phase(input int n, input int tex_pct, input int fresh_pct,
                           input int flush_pct, input bit hold, input bit drain);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      send_cmd(make_cmd(tex_pct, fresh_pct, flush_pct));
      if (hold && i == n / 3) hold_req = 1'b1;
      burst--;
      if (drain && i == n / 2) begin
        // sender waits for every pending result
        in_valid <= 1'b0;
        wait_drained();
        burst = $urandom_range(1, 12);
      end else if (i == n - 1) begin
        in_valid <= 1'b0;
      end else if (burst <= 0) begin
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // receiver: stall style is drawn anew whenever its random span runs out, long hold on request
  initial begin : rx_pattern
    int hold_left;
    int span;
    int style;
    int tick;
    hold_left = 0;
    span      = 0;
    style     = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(20, 150);
      end
      span--;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        n_holds++;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // watchdog: too long without any handshake on any channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("timeout after %0d quiet cycles, %0d results pending", IdleLimit, pending);
    $display("quad_batch_vertex_expander_top verification failed");
    $finish;
  end

  initial begin : stimulus
    foreach (recent_tex[k]) recent_tex[k] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings: max_quads 1000, empty texture 0
    send_cmd(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0));                // flush of an empty batch
    send_cmd(mk(MODE_NONE, '1, '1, '1, '1, '1, '1, '1));          // unused mode, ignored
    send_cmd(mk(MODE_COLOR, 0, 0, 0, 0, 0, 0, 0));
    // x saturates high, y saturates low
    send_cmd(mk(MODE_COLOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h1,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    // x saturates low, y saturates high
    send_cmd(mk(MODE_COLOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h55AA_55AA, 0));
    // texture ids at both ends, then hits on the bound slots
    send_cmd(mk(MODE_TEX, 32'h0010_0000, 32'h0020_0000, 0, 32'h0001_0000, 32'h0001_0000,
                0, 32'h0));
    send_cmd(mk(MODE_TEX, 32'hFFF0_0000, 32'h0000_8000, 32'h1234_5678, 32'h0002_0000,
                32'hFFFF_0000, 0, 32'hFFFF_FFFF));
    send_cmd(mk(MODE_TEX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, 32'h0));
    send_cmd(mk(MODE_TEX, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'hAA55_AA55, 32'hFFFF_FFFF));
    send_cmd(mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom));
    send_cmd(mk(MODE_COLOR, 32'hFFFF_FFFF, 32'h1, 32'h1234_5678, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'hAA55_AA55, 0));
    send_cmd(mk(MODE_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom));
    send_cmd(mk(MODE_TEX, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 0, 32'hA5A5_5A5A));
    send_cmd(mk(MODE_COLOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h0102_0304, 0));
    send_cmd(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;

    // zero acts as one quad per batch
    set_config(32'd0, 32'hFFFF_FFFF);
    run_phase(70, 50, 50, 6, 1'b0, 1'b0);
    // above the range acts as 1024, mostly new textures so the slots run out
    set_config(32'd2047, $urandom);
    run_phase(110, 92, 85, 0, 1'b1, 1'b0);
    set_config(32'd1, 32'h0);
    run_phase(50, 50, 60, 4, 1'b0, 1'b0);
    set_config(32'd3, $urandom);
    run_phase(90, 55, 40, 8, 1'b0, 1'b1);
    set_config(32'd1024, $urandom);
    run_phase(80, 70, 30, 3, 1'b1, 1'b0);
    set_config($urandom_range(2, 8), $urandom);
    run_phase(70, 50, 50, 5, 1'b0, 1'b1);

    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("sent %0d items: %0d colored, %0d textured, %0d flushes, %0d ignored",
             n_color + n_tex + n_flush + n_ignored, n_color, n_tex, n_flush, n_ignored);
    $display("%0d register settings, %0d long output holds, %0d results compared",
             n_cfg, n_holds, checked);
    if (fail_count == 0) begin
      $display("quad_batch_vertex_expander_top verification clean");
    end else begin
      $display("quad_batch_vertex_expander_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qbve_pkg.sv
rtl/qbve_slot_ram.sv
rtl/quad_batch_vertex_expander_top.sv
test/quad_expand_checker.sv
test/quad_batch_vertex_expander_top_tb.sv
